// File: hw/rtl/rtd_pkg.sv
package rtd_pkg;

   localparam int VALUE_BITS_DEF = 31;
   localparam int RADIX_W        = 6;
   localparam int CHAR_W         = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
   localparam logic [RADIX_W-1:0] LAST_NUMERIC = 6'd9;

   localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;
   localparam logic [CHAR_W-1:0] LETTER_OFFSET = 7'd55;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      if (r < RADIX_MIN) begin
         return RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         return RADIX_MAX;
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
      if (d > LAST_NUMERIC) begin
         return CHAR_W'(d) + LETTER_OFFSET;
      end
      return CHAR_W'(d) + ASCII_ZERO;
   endfunction

endpackage

// File: hw/rtl/integer_to_radix_digits_top.sv
// Flow: an accepted input is queued; the back end takes it into the divider, which finds the
// digits by repeated division and reads them out of the digit store msd first via the EMIT_RD
// and EMIT_OUT states and the strobe register; strobes are never back to back, the last one
// flagged. The one-bit-a-cycle divider sets the pace; a new item enters the back end only after
// the last digit of the one before; a two-entry queue lets up to two more be taken meanwhile.
// Reset (synchronous, high): radix back to 10, queue and sequencer empty; the receiver cannot
// stall, each digit stands on the rsp_ ports for exactly one cycle.
module integer_to_radix_digits_top #(
   parameter int VALUE_BITS = rtd_pkg::VALUE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // input transfer: start while not busy
   input  logic                           start,
   output logic                           busy,
   input  logic [VALUE_BITS-1:0]          req_value,
   // result transfer: one strobe per digit, msd first
   output logic                           rsp_strobe,
   output logic [rtd_pkg::CHAR_W-1:0]     rsp_digit_char,
   output logic                           rsp_last_digit,
   // radix register write
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rtd_pkg::RADIX_W-1:0]    csr_radix
);
   import rtd_pkg::*;

   localparam int ENT_W = VALUE_BITS + RADIX_W;

   // queue entry: clamped radix above the value, so each item keeps the
   // radix that was in force when it was taken
   logic             q_push;
   logic             q_pop;
   logic [ENT_W-1:0] q_wdata;
   logic [ENT_W-1:0] q_rdata;
   q_stat_type       q_stat;

   // front: radix register, input transfer, radix clamp
   rtd_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_value (req_value),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_radix (csr_radix),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   rtd_queue #(
      .WIDTH (ENT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .stat      (q_stat)
   );

   // back: repeated division into the digit store, then read-out msd first
   rtd_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_stat         (q_stat),
      .q_data         (q_rdata),
      .q_pop          (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

// File: hw/rtl/rtd_queue.sv
module rtd_queue #(
   parameter int WIDTH = 37
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [WIDTH-1:0]    push_data,
   input  logic                pop,
   output logic [WIDTH-1:0]    pop_data,
   output rtd_pkg::q_stat_type stat
);
   import rtd_pkg::*;

   // two entries, enough to decouple acceptance from the divider
   logic [WIDTH-1:0] ent_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            ent_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff         <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   assign pop_data   = ent_ff[rd_ptr_ff];
   assign stat.full  = cnt_ff == 2'd2;
   assign stat.empty = cnt_ff == 2'd0;

endmodule

// File: hw/rtl/rtd_front.sv
module rtd_front #(
   parameter int VALUE_BITS = 31
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [VALUE_BITS-1:0]                  req_value,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rtd_pkg::RADIX_W-1:0]            csr_radix,
   input  rtd_pkg::q_stat_type                    q_stat,
   output logic                                   q_push,
   output logic [VALUE_BITS+rtd_pkg::RADIX_W-1:0] q_data
);
   import rtd_pkg::*;

   logic [RADIX_W-1:0] radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid) begin
         radix_ff <= csr_radix;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = q_stat.full;
   assign q_push    = start & ~q_stat.full;
   // radix is clamped here so the back end only ever sees 2..36
   assign q_data    = {clamp_radix(radix_ff), req_value};

endmodule

// File: hw/rtl/rtd_back.sv
module rtd_back #(
   parameter int VALUE_BITS = 31
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rtd_pkg::q_stat_type                    q_stat,
   input  logic [VALUE_BITS+rtd_pkg::RADIX_W-1:0] q_data,
   output logic                                   q_pop,
   output logic                                   rsp_strobe,
   output logic [rtd_pkg::CHAR_W-1:0]             rsp_digit_char,
   output logic                                   rsp_last_digit
);
   import rtd_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int IDX_W = $clog2(VALUE_BITS);
   localparam int BIT_W = $clog2(VALUE_BITS);

   typedef enum logic [1:0] {
      IDLE,
      DIV,
      EMIT_RD,
      EMIT_OUT
   } state_type;

   state_type              state_ff;
   logic [VALUE_BITS-1:0]  quo_ff;
   logic [RADIX_W-1:0]     rdx_ff;
   logic [RADIX_W-1:0]     rem_ff;
   logic [BIT_W-1:0]       bit_cnt_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic                   rsp_valid_ff;
   logic [CHAR_W-1:0]      rsp_char_ff;
   logic                   rsp_last_ff;

   logic [RADIX_W-1:0]     store [VALUE_BITS];
   logic [RADIX_W-1:0]     rd_data_ff;

   logic [RADIX_W:0]       trial;
   logic                   ge;
   logic [RADIX_W:0]       rem_wide;
   logic [RADIX_W-1:0]     rem_in;
   logic [VALUE_BITS-1:0]  quo_in;
   logic                   last_bit;
   logic                   wr_en;

   // one restoring step per cycle
   assign trial    = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign ge       = trial >= {1'b0, rdx_ff};
   assign rem_wide = ge ? (trial - {1'b0, rdx_ff}) : trial;
   assign rem_in   = rem_wide[RADIX_W-1:0];
   assign quo_in   = {quo_ff[VALUE_BITS-2:0], ge};
   assign last_bit = bit_cnt_ff == BIT_W'(VALUE_BITS - 1);
   assign wr_en    = (state_ff == DIV) && last_bit;

   assign q_pop = (state_ff == IDLE) && !q_stat.empty;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[cnt_ff[IDX_W-1:0]] <= rem_in;
      end
      rd_data_ff <= store[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == EMIT_OUT);
         case (state_ff)
            IDLE: begin
               if (!q_stat.empty) begin
                  quo_ff     <= q_data[VALUE_BITS-1:0];
                  rdx_ff     <= q_data[VALUE_BITS+RADIX_W-1:VALUE_BITS];
                  rem_ff     <= '0;
                  bit_cnt_ff <= '0;
                  cnt_ff     <= '0;
                  state_ff   <= DIV;
               end
            end
            DIV: begin
               quo_ff <= quo_in;
               if (last_bit) begin
                  rem_ff     <= '0;
                  bit_cnt_ff <= '0;
                  cnt_ff     <= cnt_ff + CNT_W'(1);
                  if (quo_in == '0) begin
                     idx_ff   <= cnt_ff[IDX_W-1:0];
                     state_ff <= EMIT_RD;
                  end
               end else begin
                  rem_ff     <= rem_in;
                  bit_cnt_ff <= bit_cnt_ff + BIT_W'(1);
               end
            end
            EMIT_RD: begin
               state_ff <= EMIT_OUT;
            end
            EMIT_OUT: begin
               rsp_char_ff  <= digit_to_ascii(rd_data_ff);
               rsp_last_ff  <= idx_ff == '0;
               if (idx_ff == '0) begin
                  state_ff <= IDLE;
               end else begin
                  idx_ff   <= idx_ff - IDX_W'(1);
                  state_ff <= EMIT_RD;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("digit strobes on consecutive cycles");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV) |-> (rem_ff < rdx_ff))
      else $error("partial remainder not below radix");

   a_radix_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV) |-> (rdx_ff >= RADIX_MIN && rdx_ff <= RADIX_MAX))
      else $error("radix outside 2..36 in divider");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(VALUE_BITS))
      else $error("digit count beyond store depth");

endmodule

// File: sim/integer_to_radix_digits_top_tb.sv
`timescale 1ns / 1ps

module integer_to_radix_digits_top_tb;
   import rtd_pkg::*;

   localparam int VBITS       = VALUE_BITS_DEF;
   localparam int TEXT_W      = 31 * 8;    // room for the longest digit string (radix 2)
   localparam int QUIET_LIMIT = 5000;      // well above the quiet stretch of a 31-digit item
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 25;
   localparam int DIR_ROWS    = 20;

   // One directed row: radix to run under, value to convert, and the digit string
   // when it is obvious by eye. An all-zero string hands the row to the predictor.
   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic [VBITS-1:0]   value;
      logic [TEXT_W-1:0]  text;
   } dir_row_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } digit_item_type;

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // radix as left by reset (10)
      '{6'd10, 31'd0,          "0"},
      '{6'd10, 31'd9,          "9"},
      '{6'd10, 31'h7FFFFFFF,   "2147483647"},
      '{6'd10, 31'd1234567890, "1234567890"},
      // smallest radix: longest strings; then radix 16
      '{6'd2,  31'd0,          "0"},
      '{6'd2,  31'd1,          "1"},
      '{6'd2,  31'h7FFFFFFF,   "1111111111111111111111111111111"},
      '{6'd2,  31'h2AAAAAAA,   '0},
      '{6'd16, 31'd255,        "FF"},
      '{6'd16, 31'h7EDCBA98,   "7EDCBA98"},
      // largest radix: top letter and carry into a second digit; then radix 11
      '{6'd36, 31'd35,         "Z"},
      '{6'd36, 31'd36,         "10"},
      '{6'd36, 31'h7FFFFFFF,   '0},
      '{6'd11, 31'd10,         "A"},
      // out-of-range radix saturates to 2 below and 36 above; then radix 8 and 10
      '{6'd0,  31'd5,          "101"},
      '{6'd1,  31'd2,          "10"},
      '{6'd63, 31'd35,         "Z"},
      '{6'd37, 31'd1295,       "ZZ"},
      '{6'd8,  31'h15555555,   '0},
      '{6'd10, 31'd1,          "1"}
   };

   logic                clock;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic [VBITS-1:0]    req_value = '0;
   logic                csr_valid = 1'b0;
   logic [RADIX_W-1:0]  csr_radix = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [CHAR_W-1:0]   rsp_digit_char;
   logic                rsp_last_digit;
   logic                csr_ready;

   // TB-side mirror of the radix register, updated on each csr transfer
   logic [RADIX_W-1:0]  radix_shadow  = RADIX_RESET;
   // last radix the stimulus asked for, so directed rows only write on a change
   logic [RADIX_W-1:0]  written_radix = RADIX_RESET;

   logic [TEXT_W-1:0]   rows_pending [$];   // one per item driven but not yet taken
   digit_item_type      digits_due   [$];   // digits still owed by the block, oldest first
   int unsigned         fault_count  = 0;
   int unsigned         quiet_cycles = 0;

   integer_to_radix_digits_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_radix      (csr_radix)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Repeated division by the saturated radix; remainders come out least
   // significant first and are queued most significant first.
   function automatic void queue_digits(input logic [VBITS-1:0] value);
      logic [RADIX_W-1:0] base;
      logic [RADIX_W-1:0] rems [$];
      logic [VBITS-1:0]   quot;
      digit_item_type     item;
      base = radix_shadow;
      if (base < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (base > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      quot = value;
      // zero still gives one digit
      do begin
         rems.push_back(RADIX_W'(quot % base));
         quot = quot / base;
      end while (quot != '0);
      for (int k = rems.size() - 1; k >= 0; k--) begin
         item.digit_char = (rems[k] > LAST_NUMERIC) ? CHAR_W'(rems[k]) + LETTER_OFFSET
                                                    : CHAR_W'(rems[k]) + ASCII_ZERO;
         item.last_digit = (k == 0);
         digits_due.push_back(item);
      end
   endfunction

   // Monitor: everything sampled at the rising edge, so values are those
   // settled during the cycle just ended.
   always @(posedge clock) begin
      logic [TEXT_W-1:0] row_text;
      digit_item_type    want;
      digit_item_type    typed;
      if (!reset) begin
         quiet_cycles++;

         if (csr_valid && csr_ready) begin
            radix_shadow = csr_radix;
            quiet_cycles = 0;
         end

         // input transfer: typed digits where the row has them, else predict
         if (start && !busy) begin
            row_text = rows_pending.pop_front();
            if (row_text != '0) begin
               for (int b = 30; b >= 0; b--) begin
                  if (row_text[b*8 +: 8] != 8'd0) begin
                     typed = {row_text[b*8 +: CHAR_W], b == 0};
                     digits_due.push_back(typed);
                  end
               end
            end else begin
               queue_digits(req_value);
            end
            quiet_cycles = 0;
         end

         // result transfer: receiver cannot stall, every strobe is a digit
         if (rsp_strobe) begin
            quiet_cycles = 0;
            if (digits_due.size() == 0) begin
               $display("%0t: unexpected digit: expected none, got '%c' last %b",
                        $time, rsp_digit_char, rsp_last_digit);
               fault_count++;
            end else begin
               want = digits_due.pop_front();
               if (want.digit_char != rsp_digit_char || want.last_digit != rsp_last_digit) begin
                  $display("%0t: digit mismatch: expected '%c' last %b, got '%c' last %b",
                           $time, want.digit_char, want.last_digit,
                           rsp_digit_char, rsp_last_digit);
                  fault_count++;
               end
            end
         end
      end
   end

   // Drive one value; start is left high so back-to-back items need no
   // second assignment in the same step.
   task automatic send_value(input logic [VBITS-1:0] value, input logic [TEXT_W-1:0] text);
      rows_pending.push_back(text);
      if (!start) begin
         start <= 1'b1;
      end
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clock);
   endtask

   // Hold the sender off until every owed digit has come back.
   task automatic settle();
      start <= 1'b0;
      while (rows_pending.size() != 0 || digits_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_W-1:0] radix);
      csr_valid <= 1'b1;
      csr_radix <= radix;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      written_radix  = radix;
   endtask

   // Watchdog: ends the run if nothing transfers for too long.
   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("integer_to_radix_digits_top: mismatch");
      $finish;
   end

   initial begin
      logic [VBITS-1:0] value;
      int               span;
      int               gap_pct;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; radix only rewritten (while idle) when a row changes it
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIR_TABLE[i].radix != written_radix) begin
            settle();
            write_radix(DIR_TABLE[i].radix);
         end
         if ($urandom_range(0, 2) == 0) begin
            idle_burst();
         end
         send_value(DIR_TABLE[i].value, DIR_TABLE[i].text);
      end

      // random phases: one radix per phase, mostly legal, sometimes any 6-bit code;
      // value lengths spread so short and long strings both turn up
      for (int p = 0; p < PHASES; p++) begin
         settle();
         if ($urandom_range(0, 3) == 0) begin
            write_radix(RADIX_W'($urandom_range(0, 63)));
         end else begin
            write_radix(RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX)));
         end
         // gap density varies per phase; the last phase runs flat out
         gap_pct = (p == PHASES - 1) ? 0 : $urandom_range(0, 50);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < gap_pct) begin
               idle_burst();
            end
            span  = $urandom_range(0, VBITS);
            value = VBITS'($urandom) & ((VBITS'(1) << span) - VBITS'(1));
            send_value(value, '0);
         end
      end

      // drain, then wait out any stray digits before the final check
      settle();
      repeat (4 * VBITS) @(posedge clock);
      if (digits_due.size() != 0) begin
         $display("%0t: digits left over: expected 0, got %0d", $time, digits_due.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("integer_to_radix_digits_top: match");
      end else begin
         $display("integer_to_radix_digits_top: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/rtd_pkg.sv
hw/rtl/rtd_queue.sv
hw/rtl/rtd_front.sv
hw/rtl/rtd_back.sv
hw/rtl/integer_to_radix_digits_top.sv
sim/integer_to_radix_digits_top_tb.sv
